### rtl/core/ray_box_slab_test_core_macros.svh
// Assertion helpers for the ray/box slab test core.
`ifndef RAY_BOX_SLAB_TEST_CORE_MACROS_SVH
`define RAY_BOX_SLAB_TEST_CORE_MACROS_SVH

// Same-cycle implication, quiet during reset.
`define RBST_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rbst assertion failed");

// Next-cycle implication, quiet during reset.
`define RBST_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rbst assertion failed");

`endif

### rtl/core/rbst_pkg.sv
// ----------------------------------------------------------------------------
// rbst_pkg
// Shared constants for the ray/box slab test core.
// ----------------------------------------------------------------------------
package rbst_pkg;

  localparam int COORD_BITS_DEF = 24;
  localparam int FRAC_BITS_DEF  = 16;

  localparam int AXES  = 3;
  localparam int LANES = 2 * AXES;

  // lane = 2*axis + end
  localparam int END_ENTRY = 0;
  localparam int END_EXIT  = 1;

endpackage

### rtl/core/ray_box_slab_test_core.sv
// ----------------------------------------------------------------------------
// ray_box_slab_test_core: ray versus axis-aligned box, slab method.
// Divider: one quotient bit per stage.
// Throughput: one word per cycle while the output is not stalled; bubbles collapse behind a stalled output.
// Reset clears all valid bits only; data registers are not reset.
// ----------------------------------------------------------------------------
`include "ray_box_slab_test_core_macros.svh"

module ray_box_slab_test_core #(
  parameter int COORD_BITS = rbst_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = rbst_pkg::FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [COORD_BITS-1:0] box_min_x,
  input  logic [COORD_BITS-1:0] box_max_x,
  input  logic [COORD_BITS-1:0] box_min_y,
  input  logic [COORD_BITS-1:0] box_max_y,
  input  logic [COORD_BITS-1:0] box_min_z,
  input  logic [COORD_BITS-1:0] box_max_z,
  input  logic [COORD_BITS-1:0] ray_origin_x,
  input  logic [COORD_BITS-1:0] ray_origin_y,
  input  logic [COORD_BITS-1:0] ray_origin_z,
  input  logic [COORD_BITS-1:0] ray_dir_x,
  input  logic [COORD_BITS-1:0] ray_dir_y,
  input  logic [COORD_BITS-1:0] ray_dir_z,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  hit
);

  localparam int C  = COORD_BITS;
  localparam int F  = FRAC_BITS;
  localparam int NW = C + 1 + F;          // numerator / quotient magnitude bits
  localparam int Q  = 2 * C - F;          // saturated distance bits
  localparam int EW = ((NW > Q) ? NW : Q) + 1;
  localparam int NA = rbst_pkg::AXES;
  localparam int NL = rbst_pkg::LANES;
  localparam int SAT_ST = NW + 1;
  localparam int XY_ST  = NW + 2;
  localparam int Z_ST   = NW + 3;
  localparam int OUT_ST = NW + 4;
  localparam int NS     = NW + 5;

  localparam logic [Q-1:0]  QMAX  = {1'b0, {(Q-1){1'b1}}};
  localparam logic [Q-1:0]  QMIN  = {1'b1, {(Q-1){1'b0}}};
  localparam logic [EW-1:0] QMAXE = EW'(QMAX);
  localparam logic [EW-1:0] QHALF = EW'(QMIN);

  typedef struct packed {
    logic          neg;
    logic [C-1:0]  rem;
    logic [NW-1:0] sh;   // numerator bits out at the top, quotient bits in below
  } lane_t;

  typedef struct packed {
    lane_t [NL-1:0]        lane;
    logic  [NA-1:0][C-1:0] den;
    logic  [NA-1:0]        zero;
    logic  [NA-1:0]        ins;
  } dstage_t;

  typedef struct packed {
    logic [NL-1:0][Q-1:0] t;
    logic                 miss;
  } sat_t;

  typedef struct packed {
    logic [Q-1:0] t0;
    logic [Q-1:0] t1;
    logic [Q-1:0] za;
    logic [Q-1:0] zb;
    logic         miss;
  } xy_t;

  typedef struct packed {
    logic [Q-1:0] t0;
    logic [Q-1:0] t1;
    logic         miss;
  } zr_t;

  function automatic dstage_t div_step(dstage_t s);
    dstage_t      r;
    logic [C-1:0] r2;
    logic [C-1:0] dd;
    r = s;
    for (int l = 0; l < NL; l++) begin
      dd = s.den[l / 2];
      r2 = {s.lane[l].rem[C-2:0], s.lane[l].sh[NW-1]};
      if (r2 >= dd) begin
        r.lane[l].rem = r2 - dd;
        r.lane[l].sh  = {s.lane[l].sh[NW-2:0], 1'b1};
      end else begin
        r.lane[l].rem = r2;
        r.lane[l].sh  = {s.lane[l].sh[NW-2:0], 1'b0};
      end
    end
    return r;
  endfunction

  function automatic logic [Q-1:0] saturate(logic neg, logic [NW-1:0] mag);
    logic [EW-1:0] qe;
    logic [EW-1:0] qn;
    logic [Q-1:0]  res;
    qe = EW'(mag);
    qn = ~qe + EW'(1);
    if (neg) begin
      res = (qe > QHALF) ? QMIN : qn[Q-1:0];
    end else begin
      res = (qe > QMAXE) ? QMAX : qe[Q-1:0];
    end
    return res;
  endfunction

  // ready chain: a stage loads when it is empty or its word moves on
  logic [NS-1:0] vs;
  logic [NS:0]   rdy;

  assign rdy[NS] = out_ready;
  for (genvar i = 0; i < NS; i++) begin : g_rdy
    assign rdy[i] = !vs[i] || rdy[i+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vs <= '0;
    end else begin
      if (rdy[0]) begin
        vs[0] <= in_valid;
      end
      for (int i = 1; i < NS; i++) begin
        if (rdy[i]) begin
          vs[i] <= vs[i-1];
        end
      end
    end
  end

  assign in_ready = rdy[0];

  // front end: slab differences, magnitudes and signs
  logic [NA-1:0][C-1:0] lo, hi, org, dir;
  dstage_t              s0_next;

  assign lo  = {box_min_z, box_min_y, box_min_x};
  assign hi  = {box_max_z, box_max_y, box_max_x};
  assign org = {ray_origin_z, ray_origin_y, ray_origin_x};
  assign dir = {ray_dir_z, ray_dir_y, ray_dir_x};

  always_comb begin
    logic         dneg;
    logic [C:0]   dlo;
    logic [C:0]   dhi;
    logic [C:0]   de;
    logic [C:0]   ad;
    s0_next = '0;
    for (int a = 0; a < NA; a++) begin
      dneg = dir[a][C-1];
      dlo  = {lo[a][C-1], lo[a]} - {org[a][C-1], org[a]};
      dhi  = {hi[a][C-1], hi[a]} - {org[a][C-1], org[a]};
      s0_next.den[a]  = dneg ? (~dir[a] + C'(1)) : dir[a];
      s0_next.zero[a] = (dir[a] == '0);
      s0_next.ins[a]  = ($signed(lo[a]) <= $signed(org[a])) &&
                        ($signed(org[a]) <= $signed(hi[a]));
      for (int e = 0; e < 2; e++) begin
        if (e == rbst_pkg::END_ENTRY) begin
          de = dneg ? dhi : dlo;
        end else begin
          de = dneg ? dlo : dhi;
        end
        ad = de[C] ? (~de + (C+1)'(1)) : de;
        s0_next.lane[2*a+e].neg = de[C] ^ dneg;
        s0_next.lane[2*a+e].rem = '0;
        s0_next.lane[2*a+e].sh  = {ad, {F{1'b0}}};
      end
    end
  end

  // divider pipeline, one quotient bit per stage
  dstage_t dv [0:NW];

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      dv[0] <= s0_next;
    end
  end

  for (genvar k = 1; k <= NW; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (rdy[k]) begin
        dv[k] <= div_step(dv[k-1]);
      end
    end
  end

  // saturate, substitute unbounded slabs
  sat_t sr;

  always_ff @(posedge clk) begin
    if (rdy[SAT_ST]) begin
      for (int a = 0; a < NA; a++) begin
        if (dv[NW].zero[a]) begin
          sr.t[2*a]   <= QMIN;
          sr.t[2*a+1] <= QMAX;
        end else begin
          sr.t[2*a]   <= saturate(dv[NW].lane[2*a].neg, dv[NW].lane[2*a].sh);
          sr.t[2*a+1] <= saturate(dv[NW].lane[2*a+1].neg, dv[NW].lane[2*a+1].sh);
        end
      end
      sr.miss <= |(dv[NW].zero & ~dv[NW].ins);
    end
  end

  // x and y intersection
  xy_t xr;

  always_ff @(posedge clk) begin
    if (rdy[XY_ST]) begin
      xr.miss <= sr.miss ||
                 ($signed(sr.t[0]) > $signed(sr.t[3])) ||
                 ($signed(sr.t[2]) > $signed(sr.t[1]));
      xr.t0 <= ($signed(sr.t[2]) > $signed(sr.t[0])) ? sr.t[2] : sr.t[0];
      xr.t1 <= ($signed(sr.t[3]) < $signed(sr.t[1])) ? sr.t[3] : sr.t[1];
      xr.za <= sr.t[4];
      xr.zb <= sr.t[5];
    end
  end

  // z intersection
  zr_t zr;

  always_ff @(posedge clk) begin
    if (rdy[Z_ST]) begin
      zr.miss <= xr.miss ||
                 ($signed(xr.t0) > $signed(xr.zb)) ||
                 ($signed(xr.za) > $signed(xr.t1));
      zr.t0 <= ($signed(xr.za) > $signed(xr.t0)) ? xr.za : xr.t0;
      zr.t1 <= ($signed(xr.zb) < $signed(xr.t1)) ? xr.zb : xr.t1;
    end
  end

  // output word
  logic hit_r;

  always_ff @(posedge clk) begin
    if (rdy[OUT_ST]) begin
      hit_r <= !zr.miss && ($signed(zr.t1) > $signed(Q'(0))) &&
               ($signed(zr.t0) < $signed(zr.t1));
    end
  end

  assign out_valid = vs[OUT_ST];
  assign hit       = hit_r;

  `RBST_ASSERT_IMP(a_empty_out_accepts, !vs[OUT_ST], in_ready)
  `RBST_ASSERT_IMP(a_rem_below_den, vs[NW] && !dv[NW].zero[0],
                   dv[NW].lane[0].rem < dv[NW].den[0])
  `RBST_ASSERT_NEXT(a_front_holds, vs[0] && !rdy[1], vs[0])

endmodule

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: ray/box slab test core testbench
// Drives boxes and rays through valid/ready, predicts hit per word with a
// 64-bit integer slab-method model or a table value, and checks results in order.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CB = rbst_pkg::COORD_BITS_DEF;
  localparam int FB = rbst_pkg::FRAC_BITS_DEF;
  localparam int QB = 2 * CB - FB;
  localparam longint DMAX = (64'sd1 <<< (QB - 1)) - 1;
  localparam longint DMIN = -DMAX - 1;
  localparam int N_RAND = 1950;
  localparam int N_DIR = 12;
  localparam longint CYCLE_LIMIT = 400000;
  localparam logic [CB-1:0] CMAX = {1'b0, {(CB-1){1'b1}}};
  localparam logic [CB-1:0] CMIN = {1'b1, {(CB-1){1'b0}}};
  localparam logic [CB-1:0] ONE = CB'(1 << FB);
  localparam logic [CB-1:0] MONE = CB'(-(1 << FB));
  localparam logic [CB-1:0] HALF = CB'(1 << (FB - 1));
  localparam logic [CB-1:0] QTR = CB'(1 << (FB - 2));
  localparam logic [CB-1:0] TWO = CB'(2 << FB);
  localparam logic [CB-1:0] MTWO = CB'(-(2 << FB));
  localparam logic [CB-1:0] THREE = CB'(3 << FB);
  localparam logic [CB-1:0] FOUR = CB'(4 << FB);
  localparam logic [CB-1:0] FIVE = CB'(5 << FB);
  localparam logic [CB-1:0] EPS = CB'(1);

  typedef logic [CB-1:0] coord_t;
  // order: min_x max_x min_y max_y min_z max_z org x y z dir x y z
  typedef coord_t ray_box_t [12];
  typedef struct {
    ray_box_t f;
    int       want; // -1: predictor only
  } dir_row_t;

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready, hit;
  coord_t fld [12];
  logic [0:0] hit_q[$];
  longint cycles;
  int errors;

  ray_box_slab_test_core dut (
    .clk, .rst, .in_valid, .in_ready,
    .box_min_x(fld[0]), .box_max_x(fld[1]), .box_min_y(fld[2]),
    .box_max_y(fld[3]), .box_min_z(fld[4]), .box_max_z(fld[5]),
    .ray_origin_x(fld[6]), .ray_origin_y(fld[7]), .ray_origin_z(fld[8]),
    .ray_dir_x(fld[9]), .ray_dir_y(fld[10]), .ray_dir_z(fld[11]),
    .out_valid, .out_ready, .hit
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  function automatic longint slab_dist(longint diff, longint d);
    longint q;
    q = (diff * (64'sd1 <<< FB)) / d;
    if (q > DMAX) q = DMAX;
    if (q < DMIN) q = DMIN;
    return q;
  endfunction

  function automatic bit slab_span(coord_t lo, coord_t hi, coord_t org, coord_t d,
                                   output longint t_in, output longint t_out);
    longint l, h, o, dd;
    l = longint'($signed(lo));
    h = longint'($signed(hi));
    o = longint'($signed(org));
    dd = longint'($signed(d));
    if (dd == 0) begin
      t_in = DMIN;
      t_out = DMAX;
      return (l <= o && o <= h);
    end
    if (dd > 0) begin
      t_in = slab_dist(l - o, dd);
      t_out = slab_dist(h - o, dd);
    end else begin
      t_in = slab_dist(h - o, dd);
      t_out = slab_dist(l - o, dd);
    end
    return 1;
  endfunction

  function automatic logic ray_hits_box(ray_box_t f);
    longint t0, t1, a, b;
    if (!slab_span(f[0], f[1], f[6], f[9], t0, t1)) return 0;
    for (int ax = 1; ax < 3; ax++) begin
      if (!slab_span(f[2*ax], f[2*ax+1], f[6+ax], f[9+ax], a, b)) return 0;
      if (t0 > b || a > t1) return 0;
      if (a > t0) t0 = a;
      if (b < t1) t1 = b;
    end
    return (t1 > 0) && (t0 < t1);
  endfunction

  // valid stays high after the handshake; a gap or the caller drops it
  task automatic send_word(ray_box_t f, int want);
    int gap;
    logic exp_hit;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    for (int i = 0; i < 12; i++) fld[i] <= f[i];
    in_valid <= 1;
    do @(posedge clk); while (!in_ready);
    exp_hit = (want < 0) ? ray_hits_box(f) : want[0];
    hit_q = {hit_q, exp_hit};
  endtask

  function automatic coord_t rand_coord(int mode);
    case (mode)
      0: return coord_t'($urandom);
      1: return coord_t'($signed($urandom_range(0, 20 << FB)) - (10 << FB));
      default: return coord_t'($signed($urandom_range(0, 64)) - 32);
    endcase
  endfunction

  // mostly well-formed box around origin-ish, random rays; some raw noise
  function automatic ray_box_t rand_item();
    ray_box_t f;
    coord_t a, b;
    int m;
    m = $urandom_range(0, 9) == 0 ? 0 : ($urandom_range(0, 7) == 0 ? 2 : 1);
    for (int ax = 0; ax < 3; ax++) begin
      a = rand_coord(m);
      b = rand_coord(m);
      if (m != 0 && $signed(a) > $signed(b) && $urandom_range(0, 9) != 0) begin
        f[2*ax] = b; f[2*ax+1] = a;
      end else begin
        f[2*ax] = a; f[2*ax+1] = b;
      end
      f[6+ax] = rand_coord(m);
      f[9+ax] = $urandom_range(0, 7) == 0 ? '0 : rand_coord(m);
    end
    return f;
  endfunction

  dir_row_t dir_tab [N_DIR];

  initial begin
    // unit box at the origin region, ray from -2 along +x
    dir_tab[0] = '{'{'0, ONE, '0, ONE, '0, ONE, MTWO, HALF, HALF, ONE, '0, '0}, 1};
    // box behind the ray
    dir_tab[1] = '{'{'0, ONE, '0, ONE, '0, ONE, TWO, HALF, HALF, ONE, '0, '0}, 0};
    // zero direction, origin outside y slab
    dir_tab[2] = '{'{'0, ONE, '0, ONE, '0, ONE, MTWO, TWO, HALF, ONE, '0, '0}, 0};
    // zero direction, origin on boundary
    dir_tab[3] = '{'{'0, ONE, '0, ONE, '0, ONE, MTWO, ONE, '0, ONE, '0, '0}, -1};
    // all directions zero, origin inside: unbounded in all axes
    dir_tab[4] = '{'{'0, ONE, '0, ONE, '0, ONE, HALF, HALF, HALF, '0, '0, '0}, 1};
    // inverted box with zero direction
    dir_tab[5] = '{'{ONE, '0, '0, ONE, '0, ONE, HALF, HALF, HALF, '0, ONE, ONE}, 0};
    // negative direction
    dir_tab[6] = '{'{'0, ONE, '0, ONE, '0, ONE, THREE, HALF, HALF, MONE, '0, '0}, 1};
    // extremes: saturating quotients
    dir_tab[7] = '{'{CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, '0, '0, '0, EPS, EPS, EPS}, -1};
    dir_tab[8] = '{'{CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMAX, CMIN, CMAX,
                     CMIN, CMAX, coord_t'(-1)}, -1};
    dir_tab[9] = '{'{CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMIN, CMIN, CMIN,
                     CMAX, CMAX, CMAX}, -1};
    // disjoint x and y intervals: early reject
    dir_tab[10] = '{'{'0, ONE, FOUR, FIVE, '0, ONE, MTWO, MTWO, HALF,
                      ONE, QTR, '0}, -1};
    dir_tab[11] = '{'{'1, '1, '1, '1, '1, '1, '1, '1, '1, CMIN, CMIN, CMIN}, -1};
  end

  initial begin
    rst = 1;
    in_valid = 0;
    for (int i = 0; i < 12; i++) fld[i] = '0;
    repeat (8) @(posedge clk);
    rst <= 0;
    foreach (dir_tab[i]) send_word(dir_tab[i].f, dir_tab[i].want);
    for (int n = 0; n < N_RAND; n++) begin
      if (n == N_RAND / 2) begin
        in_valid <= 0;
        wait (hit_q.size() == 0);
      end
      send_word(rand_item(), -1);
    end
    in_valid <= 0;
    wait (hit_q.size() == 0);
    repeat (60) @(posedge clk);
    if (errors == 0) $display("ray_box_slab_test_core: match");
    else $display("ray_box_slab_test_core: mismatch");
    $finish;
  end

  // receiver: random stalls per word, with calm stretches
  int stall;
  initial begin
    out_ready = 0;
    stall = 0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        stall = (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11));
        if ((cycles / 2000) % 3 == 0) stall = 0;
      end
      if (stall > 0) begin
        stall--;
        out_ready <= 0;
      end else out_ready <= 1;
    end
  end

  always @(posedge clk) begin
    if (rst) cycles <= 0;
    else cycles <= cycles + 1;
    if (!rst && out_valid && out_ready) begin
      if (hit_q.size() == 0) begin
        $error("unexpected result word, hit=%0b", hit);
        errors++;
      end else begin
        if (hit !== hit_q[0]) begin
          $error("hit: expected %0b actual %0b", hit_q[0], hit);
          errors++;
        end
        void'(hit_q.pop_front());
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("ray_box_slab_test_core: mismatch");
      $finish;
    end
  end
endmodule

### ray_box_slab_test_core.f
+incdir+rtl/core
rtl/core/rbst_pkg.sv
rtl/core/ray_box_slab_test_core.sv
verif/tb_top.sv
